>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the store coalescing buffer.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define SCB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("store buffer assertion failed");

// Same, on the block's own clock and reset.
`define SCB_ASSERT_CLK(name, prop) `SCB_ASSERT(name, clk_i, rst_ni, prop)

`endif

>>> rtl/scb_pkg.sv
// Package for the store coalescing buffer control: sizes, codes and shared types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scb_pkg;

  // Buffer geometry.
  localparam int unsigned ENTRIES = 8;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);

  // Field widths.
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned ROB_W   = 10;
  localparam int unsigned THR_W   = 2;
  localparam int unsigned RID_W   = 16;
  localparam int unsigned AGE_W   = 32;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned ENTRY_W = 3;
  localparam int unsigned OCC_W   = 4;

  // Stream widths.
  localparam int unsigned IN_FIELDS_W  = ADDR_W + ROB_W + THR_W + RID_W + 1;
  localparam int unsigned IN_TDATA_W   = 56;
  localparam int unsigned IN_TUSER_W   = MODE_W;
  localparam int unsigned OUT_FIELDS_W = ENTRY_W + ADDR_W + THR_W + 1 + OCC_W;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned OUT_TUSER_W  = ACT_W;

  // Kind of input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_STORE = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_RESP  = 2'd2,
    MODE_FLUSH = 2'd3
  } scb_mode_e;

  // What a result item reports.
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE  = 3'd0,
    ACT_MERGE = 3'd1,
    ACT_ALLOC = 3'd2,
    ACT_ISSUE = 3'd3,
    ACT_DROP  = 3'd4
  } scb_action_e;

  typedef logic [ENTRIES-1:0][AGE_W-1:0] age_arr_t;

  // Outcome of the oldest-entry search.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

endpackage

>>> rtl/store_coalescing_buffer_control_top.sv
// Top level of the store coalescing buffer control: entry tags, flags and stream ports.
// Depends on scb_pkg and scb_oldest_pick.
//
//   channel   dir  tuser          tdata (low bit up)
//   s_axis    in   mode           line_addr, rob_id, thread, req_id, write_accepted
//   m_axis    out  action         entry, write_line_addr, write_thread, full_res, occupancy
//   cfg       in   -              evict_every_tick (write enable + data)
//
// One item is taken per cycle unless a stalled result holds it; each item passes through
// the input register and then the result register, with all entry lookups and the
// oldest search done combinationally between the two registers.
// Reset clears valid and flag bits, the tick count, the register and both stages.
// A stalled result holds the input register, and s_axis_tready then drops.
`timescale 1ns / 1ps

module store_coalescing_buffer_control_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: evict_every_tick.
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  // Input items.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [23:0] line_addr, [33:24] rob_id, [35:34] thread, [51:36] req_id,
  // [52] write_accepted, rest zero.
  input  logic [scb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] mode.
  input  logic [scb_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // Result items.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] entry, [26:3] write_line_addr, [28:27] write_thread, [29] full_res,
  // [33:30] occupancy, rest zero.
  output logic [scb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [2:0] action.
  output logic [scb_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import scb_pkg::*;

  // Input stage.
  logic              in_valid_q;
  scb_mode_e         in_mode_q;
  logic [ADDR_W-1:0] in_addr_q;
  logic [ROB_W-1:0]  in_rob_q;
  logic [THR_W-1:0]  in_thr_q;
  logic [RID_W-1:0]  in_rid_q;
  logic              in_acc_q;
  logic              proc_go;

  // Configuration and global state.
  logic             evict_q;
  logic [AGE_W-1:0] tick_q, tick_d;

  // Entry flags and tags.
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] waiting_q, waiting_d;
  logic [ENTRIES-1:0] reissue_q, reissue_d;
  logic [ADDR_W-1:0]  line_q [ENTRIES];
  logic [ROB_W-1:0]   rob_q  [ENTRIES];
  logic [THR_W-1:0]   thr_q  [ENTRIES];
  logic [RID_W-1:0]   wid_q  [ENTRIES];
  age_arr_t           age_q;

  // Per-entry write strobes.
  logic [ENTRIES-1:0] alloc_we, age_we, wid_we;

  // Lookup vectors.
  logic [ENTRIES-1:0] hit_vec, free_vec, resp_vec, flush_vec, cand_vec;
  logic               hit_found, free_found;
  logic [IDX_W-1:0]   hit_idx, free_idx;
  pick_t              pick;

  // Result of the current item.
  scb_action_e        act;
  logic [IDX_W-1:0]   ent_idx;
  logic [ADDR_W-1:0]  waddr;
  logic [THR_W-1:0]   wthr;
  logic [OCC_W-1:0]   occ;
  logic               full;

  // Output stage.
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_tdata_q;
  logic [OUT_TUSER_W-1:0] out_tuser_q;

  // Handshake between the stages.
  assign proc_go       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input payload, unpacked on capture.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= scb_mode_e'(s_axis_tuser[MODE_W-1:0]);
      in_addr_q <= s_axis_tdata[23:0];
      in_rob_q  <= s_axis_tdata[33:24];
      in_thr_q  <= s_axis_tdata[35:34];
      in_rid_q  <= s_axis_tdata[51:36];
      in_acc_q  <= s_axis_tdata[52];
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evict_q <= 1'b0;
    end else if (cfg_we_i) begin
      evict_q <= cfg_wdata_i;
    end
  end

  // Parallel compares against every entry.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid_q[i] && (line_q[i] == in_addr_q);
      free_vec[i]  = !valid_q[i];
      resp_vec[i]  = valid_q[i] && waiting_q[i] && (wid_q[i] == in_rid_q);
      flush_vec[i] = valid_q[i] && (thr_q[i] == in_thr_q) && (in_rob_q <= rob_q[i]);
      cand_vec[i]  = valid_q[i] && !waiting_q[i];
    end
  end

  // First matching entry and first free entry.
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i] && !hit_found) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (free_vec[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  scb_oldest_pick u_oldest_pick (
    .cand_i (cand_vec),
    .ages_i (age_q),
    .pick_o (pick)
  );

  // Next state and result for the item in the input stage.
  always_comb begin
    valid_d   = valid_q;
    waiting_d = waiting_q;
    reissue_d = reissue_q;
    tick_d    = tick_q;
    alloc_we  = '0;
    age_we    = '0;
    wid_we    = '0;
    act       = ACT_NONE;
    ent_idx   = '0;
    waddr     = '0;
    wthr      = '0;
    case (in_mode_q)
      MODE_STORE: begin
        if (hit_found) begin
          age_we[hit_idx] = 1'b1;
          if (waiting_q[hit_idx]) begin
            reissue_d[hit_idx] = 1'b1;
          end
          act     = ACT_MERGE;
          ent_idx = hit_idx;
        end else if (free_found) begin
          alloc_we[free_idx]  = 1'b1;
          age_we[free_idx]    = 1'b1;
          valid_d[free_idx]   = 1'b1;
          waiting_d[free_idx] = 1'b0;
          reissue_d[free_idx] = 1'b0;
          act                 = ACT_ALLOC;
          ent_idx             = free_idx;
        end else begin
          act = ACT_DROP;
        end
      end
      MODE_TICK: begin
        tick_d = tick_q + 1'b1;
        if ((evict_q || (&valid_q)) && pick.found && in_acc_q) begin
          wid_we[pick.idx]    = 1'b1;
          waiting_d[pick.idx] = 1'b1;
          reissue_d[pick.idx] = 1'b0;
          act                 = ACT_ISSUE;
          ent_idx             = pick.idx;
          waddr               = line_q[pick.idx];
          wthr                = thr_q[pick.idx];
        end
      end
      MODE_RESP: begin
        // A merged entry only drops its wait flag; others are freed.
        for (int i = 0; i < ENTRIES; i++) begin
          if (resp_vec[i]) begin
            if (reissue_q[i]) begin
              waiting_d[i] = 1'b0;
            end else begin
              valid_d[i]   = 1'b0;
              waiting_d[i] = 1'b0;
              reissue_d[i] = 1'b0;
            end
          end
        end
      end
      MODE_FLUSH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (flush_vec[i]) begin
            valid_d[i]   = 1'b0;
            waiting_d[i] = 1'b0;
            reissue_d[i] = 1'b0;
          end
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  // Occupancy after the item.
  always_comb begin
    occ = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      occ = occ + OCC_W'(valid_d[i]);
    end
    full = &valid_d;
  end

  // Flags and tick count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      waiting_q <= '0;
      reissue_q <= '0;
      tick_q    <= '0;
    end else if (proc_go) begin
      valid_q   <= valid_d;
      waiting_q <= waiting_d;
      reissue_q <= reissue_d;
      tick_q    <= tick_d;
    end
  end

  // Entry tags, written only by their own strobes.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (proc_go && alloc_we[i]) begin
        line_q[i] <= in_addr_q;
        rob_q[i]  <= in_rob_q;
        thr_q[i]  <= in_thr_q;
      end
      if (proc_go && age_we[i]) begin
        age_q[i] <= tick_q;
      end
      if (proc_go && wid_we[i]) begin
        wid_q[i] <= in_rid_q;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go) begin
      out_tuser_q <= act;
      out_tdata_q <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                      occ, full, wthr, waddr, ENTRY_W'(ent_idx)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

endmodule

>>> rtl/scb_oldest_pick.sv
// Oldest-entry picker: smallest age stamp among candidate entries, ties to lowest index.
// Depends on scb_pkg.
`timescale 1ns / 1ps

module scb_oldest_pick (
  input  logic [scb_pkg::ENTRIES-1:0] cand_i,
  input  scb_pkg::age_arr_t           ages_i,
  output scb_pkg::pick_t              pick_o
);
  import scb_pkg::*;

  logic [AGE_W-1:0] best_age;

  // Walk the entries once, keeping the best candidate so far.
  always_comb begin
    pick_o.found = 1'b0;
    pick_o.idx   = '0;
    best_age     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cand_i[i] && (!pick_o.found || ages_i[i] < best_age)) begin
        pick_o.found = 1'b1;
        pick_o.idx   = IDX_W'(i);
        best_age     = ages_i[i];
      end
    end
  end

endmodule

>>> rtl/scb_checker.sv
// Port-level checks for the store coalescing buffer control, bound to the top level.
// Depends on scb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [scb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [scb_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import scb_pkg::*;

  logic [OCC_W-1:0] occ_seen;
  logic             full_seen;

  assign occ_seen  = m_axis_tdata[33:30];
  assign full_seen = m_axis_tdata[29];

  // A stalled result item stays put.
  `SCB_ASSERT_CLK(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // The full flag agrees with the reported occupancy.
  `SCB_ASSERT_CLK(a_full_is_occ, m_axis_tvalid |-> (full_seen == (occ_seen == OCC_W'(ENTRIES))))

  // A store is dropped only when every entry is taken.
  `SCB_ASSERT_CLK(a_drop_when_full, m_axis_tvalid && (m_axis_tuser == ACT_DROP) |-> full_seen)

  // Write address and thread are zero unless a write was issued.
  `SCB_ASSERT_CLK(a_write_fields_idle, m_axis_tvalid && (m_axis_tuser != ACT_ISSUE) |-> (m_axis_tdata[28:3] == '0))

  // The input is only held off while a result item is stalled.
  `SCB_ASSERT_CLK(a_ready_unless_stalled, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)

endmodule

bind store_coalescing_buffer_control_top scb_checker u_scb_checker (.*);
